@@ hw/rtl/psc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg
// Widths, constants, register indices, sequencer states and shared structs
// for the pressure sensor compensation block.
// ----------------------------------------------------------------------------
package psc_pkg;

  // Field widths
  localparam int RAW_W     = 24;
  localparam int CAL_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int TEMP_W    = 19;
  localparam int PRES_W    = 26;
  localparam int DEPTH_W   = 24;

  // Internal widths, sized from the ranges of the calibration arithmetic
  localparam int DT_W    = 26;  // signed dT
  localparam int DTMAG_W = 25;  // |dT|
  localparam int DMAG_W  = 17;  // |TEMP - 2000|
  localparam int ACC_W   = 40;  // offset / sensitivity
  localparam int MCAND_W = 40;
  localparam int PLR_W   = 25;
  localparam int PROD_W  = 64;
  localparam int DTSQ_W  = 48;
  localparam int SQ_W    = 34;
  localparam int TI_W    = 17;
  localparam int OFFI_W  = 35;
  localparam int SENSI_W = 34;
  localparam int V_W     = 42;
  localparam int DIFF_W  = 27;
  localparam int DEP_W   = 40;  // |diff| * scale

  // Shift amounts of the compensation formulas
  localparam int T_SHIFT     = 23;
  localparam int OFF_SHIFT   = 7;
  localparam int SENS_SHIFT  = 8;
  localparam int C2_SHIFT    = 16;
  localparam int C1_SHIFT    = 15;
  localparam int TI_LO_SHIFT = 33;
  localparam int TI_HI_SHIFT = 36;
  localparam int P1_SHIFT    = 21;
  localparam int P2_SHIFT    = 13;
  localparam int DEP_SHIFT   = 16;
  localparam int PMAG_W      = V_W - P2_SHIFT;

  localparam logic signed [TEMP_W-1:0] TEMP_REF    = TEMP_W'(2000);
  localparam logic [PLR_W-1:0]         DEPTH_SCALE = PLR_W'(6663);
  localparam logic [DEP_W-1:0]         DEP_RND     = DEP_W'(65535);
  localparam logic [PMAG_W-1:0]        P_POS_LIM   = PMAG_W'(33554431);
  localparam logic [PMAG_W-1:0]        P_NEG_LIM   = PMAG_W'(33554432);
  localparam logic signed [PRES_W-1:0] P_MAX       = PRES_W'(33554431);
  localparam logic signed [PRES_W-1:0] P_MIN       = {1'b1, {(PRES_W-1){1'b0}}};

  // Request / result kinds
  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_PRES = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } cal_idx_t;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] idx;
    logic [CAL_W-1:0]     data;
  } cfg_wr_t;

  typedef struct packed {
    logic               go;
    logic [MCAND_W-1:0] mcand;
    logic [PLR_W-1:0]   plr;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_PREP,
    ST_T_MUL_C6,
    ST_T_MUL_C4,
    ST_T_MUL_C3,
    ST_T_MUL_D,
    ST_T_MUL_DT,
    ST_T_CORR,
    ST_T_APPLY,
    ST_P_MUL_SENS,
    ST_P_SUB,
    ST_P_ABS,
    ST_P_SCALE,
    ST_P_BASE,
    ST_P_MUL_DEPTH,
    ST_OUT
  } state_t;

endpackage

@@ hw/rtl/psc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_if
// Valid/ready channel interfaces: conversion requests, results and
// calibration register writes.
// ----------------------------------------------------------------------------
interface psc_in_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [psc_pkg::RAW_W-1:0] raw_adc;

  modport source (output valid, output req_type, output raw_adc, input ready);
  modport sink   (input valid, input req_type, input raw_adc, output ready);
endinterface

interface psc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              result_kind;
  logic signed [psc_pkg::TEMP_W-1:0]  temperature_centi;
  logic signed [psc_pkg::PRES_W-1:0]  pressure_tenth_mbar;
  logic signed [psc_pkg::DEPTH_W-1:0] depth_cm;

  modport source (output valid, output result_kind, output temperature_centi,
                  output pressure_tenth_mbar, output depth_cm, input ready);
  modport sink   (input valid, input result_kind, input temperature_centi,
                  input pressure_tenth_mbar, input depth_cm, output ready);
endinterface

interface psc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [psc_pkg::CFG_IDX_W-1:0] index;
  logic [psc_pkg::CAL_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/psc_cal_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_cal_regs
// The six calibration words, written one at a time by index.
// ----------------------------------------------------------------------------
module psc_cal_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  psc_pkg::cfg_wr_t wr,
  output psc_pkg::cal_t    cal
);

  psc_pkg::cal_t cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (wr.en) begin
      case (wr.idx)
        psc_pkg::REG_C1: cal_r.c1 <= wr.data;
        psc_pkg::REG_C2: cal_r.c2 <= wr.data;
        psc_pkg::REG_C3: cal_r.c3 <= wr.data;
        psc_pkg::REG_C4: cal_r.c4 <= wr.data;
        psc_pkg::REG_C5: cal_r.c5 <= wr.data;
        psc_pkg::REG_C6: cal_r.c6 <= wr.data;
        default: ;  // unused indices are dropped
      endcase
    end
  end

  assign cal = cal_r;

endmodule

@@ hw/rtl/psc_bitser_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_bitser_mul
// Unsigned shift-and-add multiplier. The multiplier operand shifts out one
// bit per cycle; finishes as soon as no set bits remain.
// ----------------------------------------------------------------------------
module psc_bitser_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  psc_pkg::mul_req_t req,
  output psc_pkg::mul_rsp_t rsp
);

  logic                         busy_r, busy_nxt;
  logic [psc_pkg::PROD_W-1:0]   mcand_r, mcand_nxt;
  logic [psc_pkg::PROD_W-1:0]   acc_r, acc_nxt;
  logic [psc_pkg::PLR_W-1:0]    plr_r, plr_nxt;

  always_comb begin
    busy_nxt  = busy_r;
    mcand_nxt = mcand_r;
    acc_nxt   = acc_r;
    plr_nxt   = plr_r;
    if (req.go) begin
      busy_nxt  = 1'b1;
      mcand_nxt = psc_pkg::PROD_W'(req.mcand);
      acc_nxt   = '0;
      plr_nxt   = req.plr;
    end else if (busy_r) begin
      if (plr_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (plr_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt = mcand_r << 1;
        plr_nxt   = plr_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    acc_r   <= acc_nxt;
    plr_r   <= plr_nxt;
  end

  assign rsp.done = busy_r && (plr_r == '0);
  assign rsp.prod = acc_r;

endmodule

@@ hw/rtl/pressure_sensor_compensation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_sensor_compensation
// Second-order temperature/pressure compensation of raw sensor conversions,
// with depth relative to the first pressure seen after reset.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one request per conversion; req_type 0 = temperature (D2),
//            1 = pressure (D1); raw_adc is the 24-bit conversion value.
//   out_ch : one result per request. result_kind 0 carries the temperature
//            in 0.01 C, 1 carries pressure in 0.1 mbar and depth in cm.
//   cfg_ch : calibration words C1..C6 at indices 0..5, always ready; write
//            only while no request is in flight.
//   Requests are taken one at a time. Each product runs through one
//   shift-and-add multiplier at one multiplier bit per cycle, with a launch
//   step and a capture step per product.
//   A temperature request uses five products (16, 16, 16, 17 and 25 bits),
//   a pressure request two (24 and 13 bits).
//   The output register decouples the sides: a new request is accepted while
//   a result waits; if the receiver stalls, the next result holds in the
//   block until the register frees.
//   Reset clears calibration, stored offset/sensitivity and the baseline;
//   the first pressure after reset becomes the baseline.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation (
  input  logic      clk,
  input  logic      rst_n,
  psc_in_if.sink    in_ch,
  psc_out_if.source out_ch,
  psc_cfg_if.sink   cfg_ch
);

  psc_pkg::state_t   state_r, state_nxt;
  psc_pkg::cal_t     cal;
  psc_pkg::cfg_wr_t  cfg_wr;
  psc_pkg::mul_req_t mul_req;
  psc_pkg::mul_rsp_t mul_rsp;

  logic in_acc;
  logic out_load;
  logic is_mul;
  logic launched_r;

  // temperature path
  logic [psc_pkg::RAW_W-1:0]          raw_r;
  logic                               dt_neg_r;
  logic [psc_pkg::DTMAG_W-1:0]        dt_mag_r;
  logic [psc_pkg::DMAG_W-1:0]         d_mag_r;
  logic                               low_r;
  logic signed [psc_pkg::TEMP_W-1:0]  temp_r;
  logic signed [psc_pkg::ACC_W-1:0]   off_r, sens_r;
  logic [psc_pkg::SQ_W-1:0]           sq_r;
  logic [psc_pkg::DTSQ_W-1:0]         dtsq_r;
  logic [psc_pkg::TI_W-1:0]           ti_r;
  logic [psc_pkg::OFFI_W-1:0]         offi_r;
  logic [psc_pkg::SENSI_W-1:0]        sensi_r;
  logic signed [psc_pkg::ACC_W-1:0]   off_acc_r, sens_acc_r;

  // pressure path
  logic signed [psc_pkg::ACC_W-1:0]   t_r;
  logic signed [psc_pkg::V_W-1:0]     v_r;
  logic                               v_neg_r;
  logic [psc_pkg::V_W-1:0]            v_mag_r;
  logic signed [psc_pkg::PRES_W-1:0]  p_r, base_r;
  logic                               base_valid_r;
  logic signed [psc_pkg::DIFF_W-1:0]  diff_r;

  // result staging and output register
  logic                               res_kind_r;
  logic signed [psc_pkg::TEMP_W-1:0]  res_temp_r;
  logic signed [psc_pkg::PRES_W-1:0]  res_pres_r;
  logic signed [psc_pkg::DEPTH_W-1:0] res_depth_r;
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_kind_r;
  logic signed [psc_pkg::TEMP_W-1:0]  out_temp_r;
  logic signed [psc_pkg::PRES_W-1:0]  out_pres_r;
  logic signed [psc_pkg::DEPTH_W-1:0] out_depth_r;

  // combinational datapath
  logic signed [psc_pkg::DT_W-1:0]    dt_s;
  logic [psc_pkg::DT_W-1:0]           dt_abs;
  logic [psc_pkg::DMAG_W-1:0]         dq;
  logic signed [psc_pkg::TEMP_W-1:0]  temp_c6;
  logic [psc_pkg::ACC_W-1:0]          off_mag, off_base, sens_mag, sens_base;
  logic [psc_pkg::DTSQ_W+1:0]         dtsq3;
  logic [psc_pkg::SQ_W+1:0]           sq3;
  logic [psc_pkg::SQ_W+2:0]           sq5;
  logic [psc_pkg::TI_W-1:0]           ti_c;
  logic [psc_pkg::OFFI_W-1:0]         offi_c;
  logic [psc_pkg::SENSI_W-1:0]        sensi_c;
  logic [psc_pkg::ACC_W-1:0]          sens_abs, t_mag;
  logic [psc_pkg::PMAG_W-1:0]         pm;
  logic [psc_pkg::PRES_W-1:0]         pm_lo;
  logic signed [psc_pkg::PRES_W-1:0]  p_c;
  logic [psc_pkg::DIFF_W-1:0]         diff_abs;
  logic [psc_pkg::DEP_W-1:0]          dep_up;
  logic [psc_pkg::DEPTH_W-1:0]        dep_floor, dep_ceil;
  logic signed [psc_pkg::DEPTH_W-1:0] dep_c;

  psc_cal_regs u_cal_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (cfg_wr),
    .cal   (cal)
  );

  psc_bitser_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr.en    = cfg_ch.valid;
  assign cfg_wr.idx   = cfg_ch.index;
  assign cfg_wr.data  = cfg_ch.data;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == psc_pkg::ST_OUT) && (!out_valid_r || out_ch.ready);
  assign is_mul   = state_r inside {psc_pkg::ST_T_MUL_C6, psc_pkg::ST_T_MUL_C4,
                                    psc_pkg::ST_T_MUL_C3, psc_pkg::ST_T_MUL_D,
                                    psc_pkg::ST_T_MUL_DT, psc_pkg::ST_P_MUL_SENS,
                                    psc_pkg::ST_P_MUL_DEPTH};

  // --- next state ---
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_ch.req_type == psc_pkg::KIND_PRES) ? psc_pkg::ST_P_MUL_SENS
                                                            : psc_pkg::ST_T_PREP;
        end
      end
      psc_pkg::ST_T_PREP:   state_nxt = psc_pkg::ST_T_MUL_C6;
      psc_pkg::ST_T_MUL_C6: if (mul_rsp.done) state_nxt = psc_pkg::ST_T_MUL_C4;
      psc_pkg::ST_T_MUL_C4: if (mul_rsp.done) state_nxt = psc_pkg::ST_T_MUL_C3;
      psc_pkg::ST_T_MUL_C3: if (mul_rsp.done) state_nxt = psc_pkg::ST_T_MUL_D;
      psc_pkg::ST_T_MUL_D:  if (mul_rsp.done) state_nxt = psc_pkg::ST_T_MUL_DT;
      psc_pkg::ST_T_MUL_DT: if (mul_rsp.done) state_nxt = psc_pkg::ST_T_CORR;
      psc_pkg::ST_T_CORR:   state_nxt = psc_pkg::ST_T_APPLY;
      psc_pkg::ST_T_APPLY:  state_nxt = psc_pkg::ST_OUT;
      psc_pkg::ST_P_MUL_SENS: if (mul_rsp.done) state_nxt = psc_pkg::ST_P_SUB;
      psc_pkg::ST_P_SUB:    state_nxt = psc_pkg::ST_P_ABS;
      psc_pkg::ST_P_ABS:    state_nxt = psc_pkg::ST_P_SCALE;
      psc_pkg::ST_P_SCALE:  state_nxt = psc_pkg::ST_P_BASE;
      psc_pkg::ST_P_BASE:   state_nxt = psc_pkg::ST_P_MUL_DEPTH;
      psc_pkg::ST_P_MUL_DEPTH: if (mul_rsp.done) state_nxt = psc_pkg::ST_OUT;
      psc_pkg::ST_OUT:      if (out_load) state_nxt = psc_pkg::ST_IDLE;
      default:              state_nxt = psc_pkg::ST_IDLE;
    endcase
  end

  // --- outputs: handshake and multiplier operands ---
  always_comb begin
    in_ch.ready   = (state_r == psc_pkg::ST_IDLE);
    mul_req.go    = is_mul && !launched_r;
    mul_req.mcand = psc_pkg::MCAND_W'(dt_mag_r);
    mul_req.plr   = psc_pkg::PLR_W'(cal.c6);
    case (state_r)
      psc_pkg::ST_T_MUL_C4: mul_req.plr = psc_pkg::PLR_W'(cal.c4);
      psc_pkg::ST_T_MUL_C3: mul_req.plr = psc_pkg::PLR_W'(cal.c3);
      psc_pkg::ST_T_MUL_D: begin
        mul_req.mcand = psc_pkg::MCAND_W'(d_mag_r);
        mul_req.plr   = psc_pkg::PLR_W'(d_mag_r);
      end
      psc_pkg::ST_T_MUL_DT: mul_req.plr = dt_mag_r;
      psc_pkg::ST_P_MUL_SENS: begin
        mul_req.mcand = sens_abs;
        mul_req.plr   = psc_pkg::PLR_W'(raw_r);
      end
      psc_pkg::ST_P_MUL_DEPTH: begin
        mul_req.mcand = psc_pkg::MCAND_W'(diff_abs);
        mul_req.plr   = psc_pkg::DEPTH_SCALE;
      end
      default: ;
    endcase
  end

  // --- datapath arithmetic ---
  always_comb begin
    dt_s   = $signed({2'b00, raw_r}) - $signed({2'b00, cal.c5, 8'h00});
    dt_abs = dt_s[psc_pkg::DT_W-1] ? -dt_s : dt_s;

    // sign-magnitude products give truncation toward zero for free
    dq      = psc_pkg::DMAG_W'(mul_rsp.prod >> psc_pkg::T_SHIFT);
    temp_c6 = dt_neg_r ? psc_pkg::TEMP_REF - psc_pkg::TEMP_W'(dq)
                       : psc_pkg::TEMP_REF + psc_pkg::TEMP_W'(dq);

    off_base  = psc_pkg::ACC_W'({cal.c2, {psc_pkg::C2_SHIFT{1'b0}}});
    off_mag   = psc_pkg::ACC_W'(mul_rsp.prod >> psc_pkg::OFF_SHIFT);
    sens_base = psc_pkg::ACC_W'({cal.c1, {psc_pkg::C1_SHIFT{1'b0}}});
    sens_mag  = psc_pkg::ACC_W'(mul_rsp.prod >> psc_pkg::SENS_SHIFT);

    // second-order terms
    dtsq3 = {1'b0, dtsq_r, 1'b0} + {2'b00, dtsq_r};
    sq3   = {1'b0, sq_r, 1'b0} + {2'b00, sq_r};
    sq5   = {1'b0, sq_r, 2'b00} + {3'b000, sq_r};
    if (low_r) begin
      ti_c    = psc_pkg::TI_W'(dtsq3 >> psc_pkg::TI_LO_SHIFT);
      offi_c  = psc_pkg::OFFI_W'(sq3 >> 1);
      sensi_c = psc_pkg::SENSI_W'(sq5 >> 3);
    end else begin
      ti_c    = psc_pkg::TI_W'(dtsq_r >> psc_pkg::TI_HI_SHIFT);
      offi_c  = psc_pkg::OFFI_W'(sq_r >> 4);
      sensi_c = '0;
    end

    sens_abs = sens_acc_r[psc_pkg::ACC_W-1] ? -sens_acc_r : sens_acc_r;
    t_mag    = psc_pkg::ACC_W'(mul_rsp.prod >> psc_pkg::P1_SHIFT);

    pm    = psc_pkg::PMAG_W'(v_mag_r >> psc_pkg::P2_SHIFT);
    pm_lo = pm[psc_pkg::PRES_W-1:0];
    if (!v_neg_r && (pm > psc_pkg::P_POS_LIM)) begin
      p_c = psc_pkg::P_MAX;
    end else if (v_neg_r && (pm > psc_pkg::P_NEG_LIM)) begin
      p_c = psc_pkg::P_MIN;
    end else begin
      p_c = v_neg_r ? -pm_lo : pm_lo;
    end

    diff_abs = diff_r[psc_pkg::DIFF_W-1] ? -diff_r : diff_r;

    // floor shift: a negative product rounds away from zero before negation.
    // |diff| < 2^26 keeps the depth inside its field, so no clamp is needed.
    dep_up    = psc_pkg::DEP_W'(mul_rsp.prod) + psc_pkg::DEP_RND;
    dep_floor = psc_pkg::DEPTH_W'(mul_rsp.prod >> psc_pkg::DEP_SHIFT);
    dep_ceil  = psc_pkg::DEPTH_W'(dep_up >> psc_pkg::DEP_SHIFT);
    dep_c     = diff_r[psc_pkg::DIFF_W-1] ? -dep_ceil : dep_floor;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // --- control registers ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= psc_pkg::ST_IDLE;
      launched_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      off_acc_r    <= '0;
      sens_acc_r   <= '0;
      base_r       <= '0;
      base_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (mul_req.go) begin
        launched_r <= 1'b1;
      end else if (mul_rsp.done) begin
        launched_r <= 1'b0;
      end
      if (state_r == psc_pkg::ST_T_APPLY) begin
        off_acc_r  <= off_r - psc_pkg::ACC_W'(offi_r);
        sens_acc_r <= sens_r - psc_pkg::ACC_W'(sensi_r);
      end
      if ((state_r == psc_pkg::ST_P_BASE) && !base_valid_r) begin
        base_r       <= p_r;
        base_valid_r <= 1'b1;
      end
    end
  end

  // --- payload registers ---
  always_ff @(posedge clk) begin
    if (in_acc) begin
      raw_r <= in_ch.raw_adc;
    end
    case (state_r)
      psc_pkg::ST_T_PREP: begin
        dt_neg_r <= dt_s[psc_pkg::DT_W-1];
        dt_mag_r <= dt_abs[psc_pkg::DTMAG_W-1:0];
      end
      psc_pkg::ST_T_MUL_C6: begin
        if (mul_rsp.done) begin
          temp_r  <= temp_c6;
          d_mag_r <= dq;
          low_r   <= dt_neg_r && (dq != '0);
        end
      end
      psc_pkg::ST_T_MUL_C4: begin
        if (mul_rsp.done) begin
          off_r <= dt_neg_r ? off_base - off_mag : off_base + off_mag;
        end
      end
      psc_pkg::ST_T_MUL_C3: begin
        if (mul_rsp.done) begin
          sens_r <= dt_neg_r ? sens_base - sens_mag : sens_base + sens_mag;
        end
      end
      psc_pkg::ST_T_MUL_D: begin
        if (mul_rsp.done) begin
          sq_r <= psc_pkg::SQ_W'(mul_rsp.prod);
        end
      end
      psc_pkg::ST_T_MUL_DT: begin
        if (mul_rsp.done) begin
          dtsq_r <= psc_pkg::DTSQ_W'(mul_rsp.prod);
        end
      end
      psc_pkg::ST_T_CORR: begin
        ti_r    <= ti_c;
        offi_r  <= offi_c;
        sensi_r <= sensi_c;
      end
      psc_pkg::ST_T_APPLY: begin
        res_kind_r  <= psc_pkg::KIND_TEMP;
        res_temp_r  <= temp_r - psc_pkg::TEMP_W'(ti_r);
        res_pres_r  <= '0;
        res_depth_r <= '0;
      end
      psc_pkg::ST_P_MUL_SENS: begin
        if (mul_rsp.done) begin
          t_r <= sens_acc_r[psc_pkg::ACC_W-1] ? -t_mag : t_mag;
        end
      end
      psc_pkg::ST_P_SUB: begin
        v_r <= psc_pkg::V_W'(t_r) - psc_pkg::V_W'(off_acc_r);
      end
      psc_pkg::ST_P_ABS: begin
        v_neg_r <= v_r[psc_pkg::V_W-1];
        v_mag_r <= v_r[psc_pkg::V_W-1] ? -v_r : v_r;
      end
      psc_pkg::ST_P_SCALE: begin
        p_r <= p_c;
      end
      psc_pkg::ST_P_BASE: begin
        // the first pressure becomes its own baseline
        diff_r <= base_valid_r ? psc_pkg::DIFF_W'(p_r) - psc_pkg::DIFF_W'(base_r) : '0;
      end
      psc_pkg::ST_P_MUL_DEPTH: begin
        if (mul_rsp.done) begin
          res_kind_r  <= psc_pkg::KIND_PRES;
          res_temp_r  <= '0;
          res_pres_r  <= p_r;
          res_depth_r <= dep_c;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_kind_r  <= res_kind_r;
      out_temp_r  <= res_temp_r;
      out_pres_r  <= res_pres_r;
      out_depth_r <= res_depth_r;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.result_kind         = out_kind_r;
  assign out_ch.temperature_centi   = out_temp_r;
  assign out_ch.pressure_tenth_mbar = out_pres_r;
  assign out_ch.depth_cm            = out_depth_r;

endmodule

@@ hw/rtl/psc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks on the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
module psc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_kind,
  input logic signed [psc_pkg::TEMP_W-1:0]  out_temp,
  input logic signed [psc_pkg::PRES_W-1:0]  out_pres,
  input logic signed [psc_pkg::DEPTH_W-1:0] out_depth
);

  // one request at a time: busy straight after taking one
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one in progress");

  a_temp_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == psc_pkg::KIND_TEMP)) |->
      ((out_pres == '0) && (out_depth == '0)))
    else $error("temperature result carries pressure or depth");

  a_pres_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == psc_pkg::KIND_PRES)) |-> (out_temp == '0))
    else $error("pressure result carries temperature");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_kind) && $stable(out_temp) &&
       $stable(out_pres) && $stable(out_depth)))
    else $error("stalled result changed");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

endmodule

bind pressure_sensor_compensation psc_checker u_psc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.result_kind),
  .out_temp  (out_ch.temperature_centi),
  .out_pres  (out_ch.pressure_tenth_mbar),
  .out_depth (out_ch.depth_cm)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pressure_sensor_compensation. A table of directed
// requests and calibration writes is followed by random phases, each under a
// fresh calibration set. A local predictor recomputes every result, or a directed
// row pins it, and each is matched field by field against the result channel.
// ----------------------------------------------------------------------------
module tb_top;
  import psc_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES      = 200;
  localparam int RAW_MAX          = (1 << RAW_W) - 1;

  // Writes to these indices must leave the calibration untouched
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

  localparam longint POW2_7   = 64'sd1 <<< 7;
  localparam longint POW2_8   = 64'sd1 <<< 8;
  localparam longint POW2_13  = 64'sd1 <<< 13;
  localparam longint POW2_15  = 64'sd1 <<< 15;
  localparam longint POW2_16  = 64'sd1 <<< 16;
  localparam longint POW2_21  = 64'sd1 <<< 21;
  localparam longint POW2_23  = 64'sd1 <<< 23;
  localparam longint POW2_33  = 64'sd1 <<< 33;
  localparam longint POW2_37  = 64'sd1 <<< 37;
  localparam longint TREF     = 64'sd2000;
  localparam longint DEPTH_MUL = 64'sd6663;
  localparam longint PRES_HI  = (64'sd1 <<< (PRES_W - 1)) - 1;
  localparam longint PRES_LO  = -(64'sd1 <<< (PRES_W - 1));
  localparam longint DEPTH_HI = (64'sd1 <<< (DEPTH_W - 1)) - 1;
  localparam longint DEPTH_LO = -(64'sd1 <<< (DEPTH_W - 1));

  typedef struct packed {
    logic                      kind;
    logic signed [TEMP_W-1:0]  temp_centi;
    logic signed [PRES_W-1:0]  pres_tenth_mbar;
    logic signed [DEPTH_W-1:0] depth;
  } comp_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_op_t;

  typedef struct packed {
    row_op_t              op;
    logic [CFG_IDX_W-1:0] idx;
    logic                 kind;
    logic [RAW_W-1:0]     value;
    logic                 pinned;
    comp_result_t         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  psc_in_if  in_if ();
  psc_out_if out_if ();
  psc_cfg_if cfg_if ();

  pressure_sensor_compensation DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state
  logic [CAL_W-1:0] cal_word [6] = '{default: '0};
  longint           sens_store    = 0;
  longint           off_store     = 0;
  longint           baseline      = 0;
  bit               baseline_seen = 1'b0;

  comp_result_t pending_results [$];

  // Pinned expectation travelling with the request being offered
  logic         req_pinned;
  comp_result_t req_want;

  int  mismatches   = 0;
  int  temp_checked = 0;
  int  pres_checked = 0;
  int  cold_temps   = 0;
  int  cal_writes   = 0;
  int  long_holds   = 0;
  int  stuck_cycles = 0;
  int  tx_gap_pct   = 0;
  int  rx_stall_pct = 0;
  bit  long_hold_req = 1'b0;

  stim_row_t directed_rows [$];

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic comp_result_t compensate(input logic kind, input logic [RAW_W-1:0] raw);
    longint       adc, d_t, t1, off, sens, dev, sq, t_corr, off_corr, sens_corr, p, dep;
    comp_result_t r;
    r = '0;
    r.kind = kind;
    adc = longint'(raw);
    if (kind == KIND_TEMP) begin
      d_t  = adc - longint'(cal_word[REG_C5]) * 256;
      t1   = TREF + d_t * longint'(cal_word[REG_C6]) / POW2_23;
      off  = longint'(cal_word[REG_C2]) * POW2_16 + longint'(cal_word[REG_C4]) * d_t / POW2_7;
      sens = longint'(cal_word[REG_C1]) * POW2_15 + longint'(cal_word[REG_C3]) * d_t / POW2_8;
      dev  = t1 - TREF;
      sq   = dev * dev;
      if (t1 < TREF) begin
        cold_temps++;
        t_corr    = 3 * (d_t * d_t) / POW2_33;
        off_corr  = 3 * sq / 2;
        sens_corr = 5 * sq / 8;
      end else begin
        t_corr    = 2 * (d_t * d_t) / POW2_37;
        off_corr  = sq / 16;
        sens_corr = 0;
      end
      off_store  = off - off_corr;
      sens_store = sens - sens_corr;
      r.temp_centi = TEMP_W'(t1 - t_corr);
    end else begin
      p = (adc * sens_store / POW2_21 - off_store) / POW2_13;
      if (p > PRES_HI) p = PRES_HI;
      else if (p < PRES_LO) p = PRES_LO;
      if (!baseline_seen) begin
        baseline      = p;
        baseline_seen = 1'b1;
      end
      // arithmetic shift of a signed value floors
      dep = ((p - baseline) * DEPTH_MUL) >>> DEP_SHIFT;
      if (dep > DEPTH_HI) dep = DEPTH_HI;
      else if (dep < DEPTH_LO) dep = DEPTH_LO;
      r.pres_tenth_mbar = PRES_W'(p);
      r.depth           = DEPTH_W'(dep);
    end
    return r;
  endfunction

  function automatic stim_row_t req_row(input logic kind, input logic [RAW_W-1:0] raw);
    stim_row_t row;
    row       = '0;
    row.op    = ROW_REQ;
    row.kind  = kind;
    row.value = raw;
    return row;
  endfunction

  function automatic stim_row_t pinned_row(input logic kind, input logic [RAW_W-1:0] raw,
                                           input int t, input int p, input int d);
    stim_row_t row;
    row                      = req_row(kind, raw);
    row.pinned               = 1'b1;
    row.want.kind            = kind;
    row.want.temp_centi      = TEMP_W'(t);
    row.want.pres_tenth_mbar = PRES_W'(p);
    row.want.depth           = DEPTH_W'(d);
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CAL_W-1:0] data);
    stim_row_t row;
    row       = '0;
    row.op    = ROW_CFG;
    row.idx   = idx;
    row.value = RAW_W'(data);
    return row;
  endfunction

  function automatic logic [RAW_W-1:0] random_raw();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return RAW_W'(RAW_MAX);
      default: return RAW_W'($urandom);
    endcase
  endfunction

  // Temperature readings scattered around the calibrated reference point
  function automatic logic [RAW_W-1:0] near_reference_raw();
    int t;
    if ($urandom_range(0, 9) == 0) return random_raw();
    t = int'(cal_word[REG_C5]) * 256 + int'($urandom_range(0, 1 << 21)) - (1 << 20);
    if (t < 0) t = 0;
    if (t > RAW_MAX) t = RAW_MAX;
    return RAW_W'(t);
  endfunction

  function automatic logic [CAL_W-1:0] random_cal_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return CAL_W'($urandom);
    endcase
  endfunction

  // Request offered with an optional idle burst first; returns at the accepting edge
  task automatic send_request(input logic kind, input logic [RAW_W-1:0] raw,
                              input logic pinned, input comp_result_t want);
    cfg_if.valid <= 1'b0;
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.req_type <= kind;
    in_if.raw_adc  <= raw;
    req_pinned     <= pinned;
    req_want       <= want;
    do @(posedge clk); while (in_if.ready !== 1'b1);
  endtask

  task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct,
                           input bit with_hold);
    int sent;
    bit hold_issued;
    sent        = 0;
    hold_issued = 1'b0;
    wait_for_drain();
    tx_gap_pct   = tx_pct;
    rx_stall_pct = rx_pct;
    write_cal(REG_C1, random_cal_word());
    write_cal(REG_C2, random_cal_word());
    write_cal(REG_C3, random_cal_word());
    write_cal(REG_C4, random_cal_word());
    write_cal(REG_C5, random_cal_word());
    write_cal(REG_C6, random_cal_word());
    if ($urandom_range(0, 2) == 0)
      write_cal($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, random_cal_word());
    while (sent < n_items) begin
      if (with_hold && !hold_issued && sent >= n_items / 2) begin
        long_hold_req = 1'b1;
        hold_issued   = 1'b1;
      end
      if ($urandom_range(0, 99) < 80) begin
        // a temperature conversion followed by a few pressure conversions
        send_request(KIND_TEMP, near_reference_raw(), 1'b0, '0);
        sent++;
        repeat ($urandom_range(1, 4)) begin
          send_request(KIND_PRES, random_raw(), 1'b0, '0);
          sent++;
        end
      end else begin
        send_request($urandom_range(0, 1) ? KIND_PRES : KIND_TEMP, random_raw(), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Predict each accepted request
  always @(posedge clk) begin : request_capture
    comp_result_t r;
    if (rst_n && in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
      r = compensate(in_if.req_type, in_if.raw_adc);
      if (req_pinned) r = req_want;
      pending_results.push_back(r);
    end
  end

  always @(posedge clk) begin : cal_capture
    if (rst_n && cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) begin
      cal_writes++;
      if (cfg_if.index <= REG_C6) cal_word[cfg_if.index] = cfg_if.data;
    end
  end

  always @(posedge clk) begin : result_check
    comp_result_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        if (want.kind == KIND_TEMP) temp_checked++;
        else pres_checked++;
        if (out_if.result_kind !== want.kind)
          report_mismatch($sformatf("result_kind got %0b, expected %0b",
                                    out_if.result_kind, want.kind));
        if (out_if.temperature_centi !== want.temp_centi)
          report_mismatch($sformatf("temperature_centi got %0d, expected %0d",
                                    out_if.temperature_centi, want.temp_centi));
        if (out_if.pressure_tenth_mbar !== want.pres_tenth_mbar)
          report_mismatch($sformatf("pressure_tenth_mbar got %0d, expected %0d",
                                    out_if.pressure_tenth_mbar, want.pres_tenth_mbar));
        if (out_if.depth_cm !== want.depth)
          report_mismatch($sformatf("depth_cm got %0d, expected %0d",
                                    out_if.depth_cm, want.depth));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("No handshake for %0d cycles, %0d results outstanding",
                 stuck_cycles, pending_results.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Result receiver: short random stalls, plus one long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        long_holds++;
        stall_left = LONG_HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        stall_left = $urandom_range(0, 4);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    bit in_cfg_run;
    in_cfg_run = 1'b0;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.req_type <= KIND_TEMP;
    in_if.raw_adc  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= REG_C1;
    cfg_if.data    <= '0;
    req_pinned     <= 1'b0;
    req_want       <= '0;

    directed_rows = {
      // zero calibration: no offset or sensitivity, first pressure is the baseline
      pinned_row(KIND_PRES, 24'h123456, 0, 0, 0),
      pinned_row(KIND_TEMP, 24'h000000, 2000, 0, 0),
      pinned_row(KIND_PRES, 24'hFFFFFF, 0, 0, 0),
      req_row(KIND_TEMP, 24'hFFFFFF),
      req_row(KIND_PRES, 24'hFFFFFF),
      // typical calibration, spare indices must be ignored
      cfg_row(REG_C1, 16'd46372),
      cfg_row(REG_C2, 16'd43981),
      cfg_row(REG_C3, 16'd29059),
      cfg_row(REG_C4, 16'd27842),
      cfg_row(REG_C5, 16'd31553),
      cfg_row(REG_C6, 16'd28165),
      cfg_row(REG_UNUSED_A, 16'hFFFF),
      cfg_row(REG_UNUSED_B, 16'h1234),
      req_row(KIND_TEMP, 24'd8569150),
      req_row(KIND_PRES, 24'd6465444),
      req_row(KIND_TEMP, 24'd8077568),   // exactly 20.00 C, warm branch
      req_row(KIND_TEMP, 24'd8077270),   // just below 20.00 C, cold branch
      req_row(KIND_PRES, 24'd6465444),
      req_row(KIND_TEMP, 24'h000000),
      req_row(KIND_PRES, 24'h000000),
      req_row(KIND_PRES, 24'hFFFFFF),
      req_row(KIND_TEMP, 24'hFFFFFF),
      req_row(KIND_PRES, 24'hFFFFFF),
      req_row(KIND_PRES, 24'h000000),
      // all calibration words at full scale
      cfg_row(REG_C1, 16'hFFFF),
      cfg_row(REG_C2, 16'hFFFF),
      cfg_row(REG_C3, 16'hFFFF),
      cfg_row(REG_C4, 16'hFFFF),
      cfg_row(REG_C5, 16'hFFFF),
      cfg_row(REG_C6, 16'hFFFF),
      req_row(KIND_TEMP, 24'h000000),
      req_row(KIND_PRES, 24'hFFFFFF),
      req_row(KIND_TEMP, 24'hFFFFFF),
      req_row(KIND_PRES, 24'h000000),
      req_row(KIND_TEMP, 24'h800000),
      req_row(KIND_PRES, 24'h7FFFFF)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_CFG) begin
        if (!in_cfg_run) wait_for_drain();
        in_cfg_run = 1'b1;
        write_cal(directed_rows[i].idx, CAL_W'(directed_rows[i].value));
      end else begin
        in_cfg_run = 1'b0;
        send_request(directed_rows[i].kind, directed_rows[i].value,
                     directed_rows[i].pinned, directed_rows[i].want);
      end
    end

    run_phase(120, 20, 20, 1'b0);
    run_phase(120, 0, 0, 1'b0);
    run_phase(120, 40, 30, 1'b1);
    run_phase(120, 10, 50, 1'b0);
    run_phase(120, 30, 0, 1'b1);
    run_phase(110, 0, 0, 1'b0);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("Run: %0d temperature and %0d pressure results compared, %0d calibration writes",
             temp_checked, pres_checked, cal_writes);
    $display("Run: %0d cold-branch temperatures, %0d long receiver hold-offs, %0d mismatches",
             cold_temps, long_holds, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
